/* rtl/ramped_pwm_pulse_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Ramped PWM pulse sequencer assertion macros
// Shared assertion forms for the checker of the sequencer.
// ----------------------------------------------------------------------------
`ifndef RAMPED_PWM_PULSE_SEQUENCER_DEFINES_SVH
`define RAMPED_PWM_PULSE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rpps_pkg.sv */
// ----------------------------------------------------------------------------
// Ramped PWM pulse sequencer package
// Operation codes, register indexes, widths and shared structures.
// ----------------------------------------------------------------------------
`default_nettype none

package rpps_pkg;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_EVENT = 2'd2,
		OP_STOP  = 2'd3
	} rpps_op_t;

	// Reported phase of the burst.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_UP     = 2'd1,
		PH_STEADY = 2'd2,
		PH_DOWN   = 2'd3
	} rpps_phase_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TARGET = 2'd0;
	localparam logic [1:0] CFG_DUTY   = 2'd1;
	localparam logic [1:0] CFG_RAMP   = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [15:0] TARGET_RST = 16'd1000;
	localparam logic [6:0]  DUTY_RST   = 7'd50;

	// Duty limit and reciprocal of one hundred, scaled by two to the thirtieth.
	localparam logic [6:0]  DUTY_MAX   = 7'd100;
	localparam logic [23:0] RECIP_100  = 24'd10737419;
	localparam int          RECIP_SHIFT = 30;

	// Settings seen by the sequencer core.
	typedef struct packed {
		logic [15:0] target;
		logic        ramp;
		logic [15:0] duty_cmp;
	} rpps_cfg_t;

	// One result beat.
	typedef struct packed {
		logic        done;
		rpps_phase_t phase;
		logic        running;
		logic [15:0] compare;
		logic [15:0] period;
	} rpps_res_t;

endpackage

`default_nettype wire

/* rtl/rpps_core.sv */
// ----------------------------------------------------------------------------
// Ramped PWM pulse sequencer core
// Holds the timer state and works out the next state and result of one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rpps_core
	import rpps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire rpps_op_t    op,
	input  wire logic [31:0] count,
	input  wire rpps_cfg_t   cfg,
	output rpps_res_t        res
);

	logic [15:0] period_q, period_d;
	logic [15:0] compare_q, compare_d;
	logic [31:0] up_left_q, up_left_d;
	logic [31:0] steady_left_q, steady_left_d;
	logic [31:0] down_left_q, down_left_d;
	logic        running_q, running_d;
	logic        event_en_q, event_en_d;
	logic [15:0] lat_period_q, lat_period_d;
	logic        lat_ramp_q, lat_ramp_d;
	logic        done_d;
	logic [19:0] span;
	logic [15:0] target_x10;
	logic [15:0] target_x5;

	// Ramp span of nine periods and the preset values for gradual mode.
	assign span       = {1'b0, lat_period_q, 3'b000} + {4'b0000, lat_period_q};
	assign target_x10 = {cfg.target[12:0], 3'b000} + {cfg.target[14:0], 1'b0};
	assign target_x5  = {cfg.target[13:0], 2'b00} + cfg.target;

	// Next state for the operation of the beat.
	always_comb begin
		period_d      = period_q;
		compare_d     = compare_q;
		up_left_d     = up_left_q;
		steady_left_d = steady_left_q;
		down_left_d   = down_left_q;
		running_d     = running_q;
		event_en_d    = event_en_q;
		lat_period_d  = lat_period_q;
		lat_ramp_d    = lat_ramp_q;
		done_d        = 1'b0;
		case (op)
			OP_LOAD: begin
				running_d    = 1'b0;
				event_en_d   = 1'b0;
				lat_period_d = cfg.target;
				lat_ramp_d   = cfg.ramp;
				if (cfg.ramp) begin
					period_d  = target_x10;
					compare_d = target_x5;
				end else begin
					period_d  = cfg.target;
					compare_d = cfg.duty_cmp;
				end
			end
			OP_START: begin
				if (!lat_ramp_q) begin
					up_left_d     = '0;
					down_left_d   = '0;
					steady_left_d = count;
				end else if (count >= {12'd0, span}) begin
					up_left_d     = {13'd0, span[19:1]} + {31'd0, span[0]};
					down_left_d   = {13'd0, span[19:1]};
					steady_left_d = count - {12'd0, span};
				end else begin
					up_left_d     = {1'b0, count[31:1]} + {31'd0, count[0]};
					down_left_d   = {1'b0, count[31:1]};
					steady_left_d = '0;
				end
				if (count != '0) begin
					event_en_d = 1'b1;
				end
				running_d = 1'b1;
			end
			OP_EVENT: begin
				if (running_q && event_en_q) begin
					if (up_left_q != '0) begin
						up_left_d = up_left_q - 32'd1;
						period_d  = period_q - 16'd2;
						compare_d = compare_q - 16'd1;
					end else if (steady_left_q != '0) begin
						steady_left_d = steady_left_q - 32'd1;
					end else if (down_left_q != '0) begin
						down_left_d = down_left_q - 32'd1;
						period_d    = period_q + 16'd2;
						compare_d   = compare_q + 16'd1;
					end else begin
						running_d  = 1'b0;
						event_en_d = 1'b0;
						done_d     = 1'b1;
					end
				end
			end
			default: begin
				running_d     = 1'b0;
				up_left_d     = '0;
				steady_left_d = '0;
				down_left_d   = '0;
			end
		endcase
	end

	// Result of the beat, taken from the updated state.
	always_comb begin
		res.period  = period_d;
		res.compare = compare_d;
		res.running = running_d;
		res.done    = done_d;
		if (!running_d) begin
			res.phase = PH_IDLE;
		end else if (up_left_d != '0) begin
			res.phase = PH_UP;
		end else if (steady_left_d != '0) begin
			res.phase = PH_STEADY;
		end else if (down_left_d != '0) begin
			res.phase = PH_DOWN;
		end else begin
			res.phase = PH_STEADY;
		end
	end

	// State update on each accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= '0;
			compare_q     <= '0;
			up_left_q     <= '0;
			steady_left_q <= '0;
			down_left_q   <= '0;
			running_q     <= 1'b0;
			event_en_q    <= 1'b0;
			lat_period_q  <= '0;
			lat_ramp_q    <= 1'b0;
		end else if (fire) begin
			period_q      <= period_d;
			compare_q     <= compare_d;
			up_left_q     <= up_left_d;
			steady_left_q <= steady_left_d;
			down_left_q   <= down_left_d;
			running_q     <= running_d;
			event_en_q    <= event_en_d;
			lat_period_q  <= lat_period_d;
			lat_ramp_q    <= lat_ramp_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/ramped_pwm_pulse_sequencer.sv */
// A result beat is registered in the output stage before it appears on the master side.
// Throughput: one beat per cycle while the slave side is not stalled; the state update is a single registered pass.
// A two-entry output stage keeps accepting while one result waits to be taken.
// After reset and after each configuration write the slave side stalls while the duty
// product register settles. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
// Ramped PWM pulse sequencer
// Runs bursts of PWM periods with an optional trapezoidal period ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module ramped_pwm_pulse_sequencer
	import rpps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] pulse_count
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	// Result beats.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] period_ticks_now, [31:16] compare_ticks_now, [32] timer_running,
	// [34:33] phase, [39:35] zero
	output logic [39:0]      m_tdata,
	output logic             m_tlast,   // done_res
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic        s_fire;
	logic        m_fire;
	logic        cfg_fire;
	logic [15:0] target_q;
	logic [6:0]  duty_q;
	logic        ramp_q;
	logic        hold_q;
	logic [6:0]  duty_sat;
	logic [22:0] prod_q;
	logic [46:0] quot_full;
	rpps_cfg_t   cfg;
	rpps_res_t   res;
	rpps_res_t   out_q;
	rpps_res_t   skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign s_fire    = s_tvalid & s_tready;
	assign m_fire    = m_tvalid & m_tready;
	assign s_tready  = !hold_q && !skid_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			duty_q   <= DUTY_RST;
			ramp_q   <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_TARGET: target_q <= cfg_data;
				CFG_DUTY:   duty_q   <= cfg_data[6:0];
				CFG_RAMP:   ramp_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Stall after reset or a write so the product register is current.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b1;
		end else begin
			hold_q <= cfg_fire;
		end
	end

	// Duty times period, then a reciprocal multiply for the division by one hundred.
	assign duty_sat = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;

	always_ff @(posedge clk) begin
		prod_q <= {16'd0, duty_sat} * {7'd0, target_q};
	end

	assign quot_full = {24'd0, prod_q} * {23'd0, RECIP_100};

	assign cfg.target   = target_q;
	assign cfg.ramp     = ramp_q;
	assign cfg.duty_cmp = quot_full[RECIP_SHIFT+15:RECIP_SHIFT];

	// Sequencer state and next result.
	rpps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s_fire),
		.op     (rpps_op_t'(s_tuser)),
		.count  (s_tdata),
		.cfg    (cfg),
		.res    (res)
	);

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q && m_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (s_fire && (!out_valid_q || m_fire)) begin
				out_valid_q <= 1'b1;
			end else if (s_fire) begin
				skid_valid_q <= 1'b1;
			end else if (m_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && m_fire) begin
			out_q <= skid_q;
		end else if (s_fire && (!out_valid_q || m_fire)) begin
			out_q <= res;
		end else if (s_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.phase, out_q.running, out_q.compare, out_q.period};
	assign m_tlast  = out_q.done;

endmodule

`default_nettype wire

/* rtl/rpps_checker.sv */
// ----------------------------------------------------------------------------
// Ramped PWM pulse sequencer checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ramped_pwm_pulse_sequencer_defines.svh"

module rpps_checker
	import rpps_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	logic        res_run;
	logic        res_idle;
	logic [40:0] res_beat;

	// Fields of the result beat on show.
	assign res_run  = m_tdata[32];
	assign res_idle = (m_tdata[34:33] == PH_IDLE);
	assign res_beat = {m_tlast, m_tdata};

	// The finishing beat reports a stopped timer in the idle phase.
	`RPPS_ASSERT_SAME(a_done_idle, m_tvalid && m_tlast, !res_run && res_idle, "done beat not idle")

	// A stopped timer always reports the idle phase.
	`RPPS_ASSERT_SAME(a_stop_phase, m_tvalid && !res_run, res_idle, "stopped timer not idle")

	// A running timer never reports the idle phase.
	`RPPS_ASSERT_SAME(a_run_phase, m_tvalid && res_run, !res_idle, "running timer idle")

	// A stalled result beat holds.
	`RPPS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(res_beat), "stall moved")

endmodule

bind ramped_pwm_pulse_sequencer rpps_checker u_rpps_checker (.*);

`default_nettype wire
